@@ hw/rtl/pdsch_pkg.sv @@
// ----------------------------------------------------------------------------
// pdsch_pkg: shared types and constants of the periodic deadline scheduler
// Result codes, list entry layout and the command word sent to each cell.
// ----------------------------------------------------------------------------
package pdsch_pkg;

	localparam int SLOTS_DEF = 32;
	localparam int MAX_OUT   = 32;
	localparam int US_PER_MS = 1000;
	localparam int KEEP_W    = 32;
	localparam int SLOT_OUT_W = 5;

	typedef enum logic [1:0] {
		KIND_OK   = 2'd0,
		KIND_FULL = 2'd1,
		KIND_DUE  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] deadline;
		logic [31:0] period;
		logic [31:0] tag;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t new_e;
	} cell_cmd_t;

endpackage

@@ hw/rtl/pdsch_if.sv @@
// ----------------------------------------------------------------------------
// pdsch_req_if / pdsch_rsp_if: valid/ready channels of the scheduler
// Request words carry timer commands, response words carry results.
// ----------------------------------------------------------------------------
interface pdsch_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] now_us;
	logic [21:0] period_ms;
	logic [31:0] tag;
	logic [31:0] keep_mask;

	modport source (output valid, mode, now_us, period_ms, tag, keep_mask, input ready);
	modport sink (input valid, mode, now_us, period_ms, tag, keep_mask, output ready);
endinterface

interface pdsch_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [4:0]  slot;
	logic [31:0] due_tag;
	logic        last;

	modport source (output valid, kind, slot, due_tag, last, input ready);
	modport sink (input valid, kind, slot, due_tag, last, output ready);
endinterface

@@ hw/rtl/pdsch_cell.sv @@
// ----------------------------------------------------------------------------
// pdsch_cell: one position of the deadline-sorted timer list
// Holds one entry; shifts toward the head on pop, away from it on insert.
// ----------------------------------------------------------------------------
module pdsch_cell
	import pdsch_pkg::*;
#(
	parameter int SW      = 5,
	parameter bit IS_HEAD = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_cmd_t     cmd,
	input  logic [SW-1:0] new_slot,
	input  logic          l_valid,
	input  logic          l_before,
	input  entry_t        l_e,
	input  logic [SW-1:0] l_slot,
	input  logic          r_valid,
	input  entry_t        r_e,
	input  logic [SW-1:0] r_slot,
	output logic          valid,
	output logic          ahead,
	output entry_t        e,
	output logic [SW-1:0] slot
);

	logic          valid_q;
	entry_t        e_q;
	logic [SW-1:0] slot_q;

	// head keeps its place on a tie, later cells only when strictly earlier
	always_comb begin
		if (IS_HEAD) begin
			ahead = valid_q && !(cmd.new_e.deadline < e_q.deadline);
		end else begin
			ahead = valid_q && (e_q.deadline < cmd.new_e.deadline);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= r_valid;
		end else if (cmd.ins && !ahead) begin
			valid_q <= (IS_HEAD || l_before) ? 1'b1 : l_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			e_q    <= r_e;
			slot_q <= r_slot;
		end else if (cmd.ins && !ahead) begin
			if (IS_HEAD || l_before) begin
				e_q    <= cmd.new_e;
				slot_q <= new_slot;
			end else begin
				e_q    <= l_e;
				slot_q <= l_slot;
			end
		end
	end

	assign valid = valid_q;
	assign e     = e_q;
	assign slot  = slot_q;

endmodule

@@ hw/rtl/periodic_deadline_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_deadline_scheduler: sorted queue of periodic timers
// Row of list cells ordered by deadline plus a small sequencer.
// ----------------------------------------------------------------------------
// Timers live in a row of SLOTS cells kept sorted by unsigned deadline; cell 0
// is the head. An add word takes the word, multiplies, then does a parallel
// insert, plus any wait on the response side. A service word takes the word,
// then pops each due timer, freeing it or reinserting it when rescheduled,
// and ends the run with a final check that finds no more due; each step is
// one pop or one insert across the whole cell row. Results pass through one
// output register, and a new request word is taken as soon as the sequencer
// is idle, even while the final result still waits to be taken.
module periodic_deadline_scheduler
	import pdsch_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pdsch_req_if.sink    req,
	pdsch_rsp_if.source  rsp
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW = $clog2(MAX_OUT + 1);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_ADD_MUL = 5'b00010,
		S_ADD_INS = 5'b00100,
		S_CHK     = 5'b01000,
		S_REINS   = 5'b10000
	} state_t;

	state_t         state_q;
	logic [31:0]    now_q;
	logic [21:0]    pms_q;
	logic [31:0]    keep_q;
	logic [31:0]    period_q;
	logic [31:0]    tag_q;
	logic [SW-1:0]  slot_q;
	logic [NW-1:0]  n_q;
	logic           pend_q;
	logic [SLOTS-1:0] in_use_q;

	// output register
	logic        out_v_q;
	kind_t       kind_q;
	logic [4:0]  oslot_q;
	logic [31:0] otag_q;
	logic        olast_q;

	// cell row, index SLOTS is the empty slot past the tail
	logic          c_v [SLOTS+1];
	logic          c_b [SLOTS];
	entry_t        c_e [SLOTS+1];
	logic [SW-1:0] c_s [SLOTS+1];
	cell_cmd_t     cmd;

	logic          out_free;
	logic          wr_out;
	kind_t         wr_kind;
	logic [4:0]    wr_slot;
	logic [31:0]   wr_tag;
	logic          wr_last;
	logic [SW-1:0] free_idx;
	logic          any_free;
	logic [31:0]   prod;
	logic          due;
	logic [31:0]   head_ext;
	logic          kept;
	logic [31:0]   slot_ext;

	assign c_v[SLOTS] = 1'b0;
	assign c_e[SLOTS] = '0;
	assign c_s[SLOTS] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		if (i == 0) begin : g_head
			pdsch_cell #(.SW(SW), .IS_HEAD(1'b1)) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd), .new_slot(slot_q),
				.l_valid(1'b0), .l_before(1'b0), .l_e('0), .l_slot('0),
				.r_valid(c_v[1]), .r_e(c_e[1]), .r_slot(c_s[1]),
				.valid(c_v[0]), .ahead(c_b[0]), .e(c_e[0]), .slot(c_s[0])
			);
		end else begin : g_body
			pdsch_cell #(.SW(SW), .IS_HEAD(1'b0)) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd), .new_slot(slot_q),
				.l_valid(c_v[i-1]), .l_before(c_b[i-1]), .l_e(c_e[i-1]),
				.l_slot(c_s[i-1]),
				.r_valid(c_v[i+1]), .r_e(c_e[i+1]), .r_slot(c_s[i+1]),
				.valid(c_v[i]), .ahead(c_b[i]), .e(c_e[i]), .slot(c_s[i])
			);
		end
	end

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_idx = SW'(i);
			end
		end
	end
	assign any_free = ~&in_use_q;

	assign prod     = {10'b0, pms_q} * 32'(US_PER_MS);
	assign out_free = !out_v_q || rsp.ready;
	assign due      = c_v[0] && ($signed(now_q) > $signed(c_e[0].deadline))
		&& (n_q < NW'(MAX_OUT));
	assign head_ext = 32'(c_s[0]);
	assign kept     = (head_ext < 32'(KEEP_W)) && keep_q[head_ext[4:0]];
	assign slot_ext = 32'(slot_q);

	always_comb begin
		// insert entry: deadline is now plus the working period
		cmd.new_e.deadline = now_q + period_q;
		cmd.new_e.period   = period_q;
		cmd.new_e.tag      = tag_q;
		cmd.ins = 1'b0;
		cmd.pop = 1'b0;
		wr_out  = 1'b0;
		wr_kind = KIND_OK;
		wr_slot = '0;
		wr_tag  = '0;
		wr_last = 1'b1;
		unique case (state_q)
			S_ADD_MUL: begin
				if (!any_free && out_free) begin
					wr_out  = 1'b1;
					wr_kind = KIND_FULL;
				end
			end
			S_ADD_INS: begin
				if (out_free) begin
					cmd.ins = 1'b1;
					wr_out  = 1'b1;
					wr_kind = KIND_OK;
					wr_slot = slot_ext[4:0];
				end
			end
			S_CHK: begin
				if (!pend_q || out_free) begin
					cmd.pop = due;
					wr_out  = pend_q;
					wr_kind = KIND_DUE;
					wr_slot = slot_ext[4:0];
					wr_tag  = tag_q;
					wr_last = !due;
				end
			end
			S_REINS: begin
				cmd.ins = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			in_use_q <= '0;
			pend_q   <= 1'b0;
			n_q      <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (wr_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						pend_q  <= 1'b0;
						n_q     <= '0;
						state_q <= req.mode ? S_CHK : S_ADD_MUL;
					end
				end
				S_ADD_MUL: begin
					if (any_free) begin
						state_q <= S_ADD_INS;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_ADD_INS: begin
					if (out_free) begin
						in_use_q[slot_q] <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				S_CHK: begin
					if (!pend_q || out_free) begin
						if (due) begin
							pend_q <= 1'b1;
							n_q    <= n_q + NW'(1);
							if (kept) begin
								state_q <= S_REINS;
							end else begin
								in_use_q[c_s[0]] <= 1'b0;
							end
						end else begin
							pend_q  <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				S_REINS: begin
					state_q <= S_CHK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers: latch the word, the period and new slot, the popped head, or a result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			now_q  <= req.now_us;
			pms_q  <= req.period_ms;
			keep_q <= req.keep_mask;
			tag_q  <= req.tag;
		end
		if (state_q == S_ADD_MUL) begin
			period_q <= prod;
			slot_q   <= free_idx;
		end
		if (cmd.pop) begin
			period_q <= c_e[0].period;
			tag_q    <= c_e[0].tag;
			slot_q   <= c_s[0];
		end
		if (wr_out) begin
			kind_q  <= wr_kind;
			oslot_q <= wr_slot;
			otag_q  <= wr_tag;
			olast_q <= wr_last;
		end
	end

	assign rsp.valid   = out_v_q;
	assign rsp.kind    = kind_q;
	assign rsp.slot    = oslot_q;
	assign rsp.due_tag = otag_q;
	assign rsp.last    = olast_q;

endmodule
